// ----- hw/rtl/csp_pkg.sv -----
// shared types and constants for the compaction segment picker
package csp_pkg;

	localparam int OVH_W = 16;
	localparam int IDX_OUT_W = 6;
	localparam int BYTES_OUT_W = 54;
	localparam int STATUS_W = 2;

	localparam logic [OVH_W-1:0] OVERHEAD_RESET = 16'd91;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CLAMP = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_TAIL,
		ST_CLOSE,
		ST_EXT_RD,
		ST_EXT_CHK,
		ST_EMIT
	} csp_state_t;

	typedef struct packed {
		logic accept;
		logic scan_rd;
		logic close;
		logic ext_rd;
		logic ext_chk;
		logic emit;
	} csp_cmd_t;

	typedef struct packed {
		logic rd_last;
		logic found;
		logic start_zero;
		logic start_one;
		logic ext_stop;
		logic out_free;
	} csp_sts_t;

endpackage

// ----- hw/rtl/csp_if.sv -----
// valid/ready channel interfaces for tables, results and configuration

interface csp_table_if #(
	parameter int SIZE_BITS = 48
);
	logic                 valid;
	logic                 ready;
	logic [SIZE_BITS-1:0] table_size;
	logic                 last_table;

	modport source (output valid, table_size, last_table, input ready);
	modport sink (input valid, table_size, last_table, output ready);
endinterface

interface csp_result_if;
	import csp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   compact_needed;
	logic [IDX_OUT_W-1:0]   range_first;
	logic [IDX_OUT_W-1:0]   range_last;
	logic [BYTES_OUT_W-1:0] range_bytes;
	logic [STATUS_W-1:0]    status;

	modport source (output valid, compact_needed, range_first, range_last, range_bytes,
		status, input ready);
	modport sink (input valid, compact_needed, range_first, range_last, range_bytes,
		status, output ready);
endinterface

interface csp_cfg_if;
	import csp_pkg::*;
	logic             valid;
	logic             ready;
	logic [OVH_W-1:0] overhead_bytes;

	modport source (output valid, overhead_bytes, input ready);
	modport sink (input valid, overhead_bytes, output ready);
endinterface

// ----- hw/rtl/csp_ram.sv -----
// generic single-port ram with registered read
module csp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hw/rtl/csp_ctrl.sv -----
// sequencer for load, run scan, backward extension and result transfer
module csp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  csp_pkg::csp_sts_t sts,
	output csp_pkg::csp_cmd_t cmd
);
	import csp_pkg::*;

	csp_state_t state_q;
	csp_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && in_last) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.rd_last) begin
					state_nxt = ST_TAIL;
				end
			end
			ST_TAIL: state_nxt = ST_CLOSE;
			ST_CLOSE: state_nxt = ST_EXT_RD;
			ST_EXT_RD: begin
				if (!sts.found || sts.start_zero) begin
					state_nxt = ST_EMIT;
				end else begin
					state_nxt = ST_EXT_CHK;
				end
			end
			ST_EXT_CHK: begin
				if (sts.ext_stop || sts.start_one) begin
					state_nxt = ST_EMIT;
				end else begin
					state_nxt = ST_EXT_RD;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_nxt = ST_LOAD;
				end
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			ST_SCAN: cmd.scan_rd = 1'b1;
			ST_TAIL: cmd = '0;
			ST_CLOSE: cmd.close = 1'b1;
			ST_EXT_RD: cmd.ext_rd = sts.found && !sts.start_zero;
			ST_EXT_CHK: cmd.ext_chk = 1'b1;
			ST_EMIT: cmd.emit = sts.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

// ----- hw/rtl/csp_datapath.sv -----
// size store, run tracking, range extension and result register
module csp_datapath #(
	parameter int MAX_TABLES = 64,
	parameter int SIZE_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [csp_pkg::OVH_W-1:0]       cfg_data,
	input  logic [SIZE_BITS-1:0]            table_size,
	input  csp_pkg::csp_cmd_t               cmd,
	output csp_pkg::csp_sts_t               sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            compact_needed,
	output logic [csp_pkg::IDX_OUT_W-1:0]   range_first,
	output logic [csp_pkg::IDX_OUT_W-1:0]   range_last,
	output logic [csp_pkg::BYTES_OUT_W-1:0] range_bytes,
	output logic [csp_pkg::STATUS_W-1:0]    status
);
	import csp_pkg::*;

	localparam int ADDR_W = $clog2(MAX_TABLES);
	localparam int CNT_W = $clog2(MAX_TABLES + 1);
	localparam int SUM_W = SIZE_BITS + CNT_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TABLES);

	// fill all bits below the leading one, so equal masks mean equal floor(log2)
	function automatic logic [SIZE_BITS-1:0] smear_e(input logic [SIZE_BITS-1:0] v);
		logic [SIZE_BITS-1:0] s;
		s = v;
		for (int k = 1; k < SIZE_BITS; k = k * 2) begin
			s = s | (s >> k);
		end
		return s;
	endfunction

	function automatic logic [SUM_W-1:0] smear_s(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] s;
		s = v;
		for (int k = 1; k < SUM_W; k = k * 2) begin
			s = s | (s >> k);
		end
		return s;
	endfunction

	logic [OVH_W-1:0]     overhead_q;
	logic [CNT_W-1:0]     count_q;
	logic                 clamp_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 proc_s1;
	logic [CNT_W-1:0]     proc_idx_s1;
	logic [CNT_W-1:0]     run_start_q;
	logic [SIZE_BITS-1:0] run_smear_q;
	logic [SUM_W-1:0]     run_bytes_q;
	logic                 found_q;
	logic [SIZE_BITS-1:0] best_smear_q;
	logic [CNT_W-1:0]     best_start_q;
	logic [CNT_W-1:0]     best_end_q;
	logic [SUM_W-1:0]     best_bytes_q;
	logic [SUM_W-1:0]     best_smear_b_q;
	logic                 out_valid_q;

	logic                 full;
	logic                 small_size;
	logic [SIZE_BITS-1:0] ovh_ext;
	logic [SIZE_BITS-1:0] adj_size;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_addr;
	logic [SIZE_BITS-1:0] rdata;
	logic [SUM_W-1:0]     rd_ext;
	logic [SIZE_BITS-1:0] rd_smear;
	logic [CNT_W-1:0]     prev_idx;
	logic                 proc_first;
	logic                 cls;
	logic [CNT_W-1:0]     cls_end;
	logic                 cand;
	logic                 ext_stop;
	logic [CNT_W-1:0]     last_idx;
	logic [CNT_W+IDX_OUT_W-1:0] first_wide;
	logic [CNT_W+IDX_OUT_W-1:0] last_wide;
	logic [SUM_W+BYTES_OUT_W-1:0] bytes_wide;

	assign full = (count_q == FULL_CNT);
	assign ovh_ext = {{(SIZE_BITS-OVH_W){1'b0}}, overhead_q};
	assign small_size = (table_size <= ovh_ext);
	assign adj_size = small_size ? SIZE_BITS'(1) : (table_size - ovh_ext);

	assign prev_idx = best_start_q - CNT_W'(1);
	assign ram_we = cmd.accept && !full;

	always_comb begin
		priority if (cmd.accept) begin
			ram_addr = count_q[ADDR_W-1:0];
		end else if (cmd.ext_rd) begin
			ram_addr = prev_idx[ADDR_W-1:0];
		end else begin
			ram_addr = rd_idx_q[ADDR_W-1:0];
		end
	end

	csp_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_TABLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (adj_size),
		.rdata (rdata)
	);

	assign rd_ext = {{CNT_W{1'b0}}, rdata};
	assign rd_smear = smear_e(rdata);

	// a run closes on a log change during the scan, and once more at the end of the list
	assign proc_first = (proc_idx_s1 == '0);
	assign cls = (proc_s1 && !proc_first && (rd_smear != run_smear_q)) || cmd.close;
	assign cls_end = cmd.close ? count_q : proc_idx_s1;
	assign cand = cls && ((cls_end - run_start_q) >= CNT_W'(2))
		&& (!found_q || (run_smear_q < best_smear_q));

	// older table joins only if floor(log2(range bytes)) is not below its log
	assign ext_stop = (best_smear_b_q < rd_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overhead_q <= OVERHEAD_RESET;
			count_q <= '0;
			clamp_q <= 1'b0;
			ovf_q <= 1'b0;
			rd_idx_q <= '0;
			proc_s1 <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				overhead_q <= cfg_data;
			end
			if (cmd.emit) begin
				count_q <= '0;
				clamp_q <= 1'b0;
				ovf_q <= 1'b0;
				rd_idx_q <= '0;
			end else begin
				if (cmd.accept) begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
					if (small_size) begin
						clamp_q <= 1'b1;
					end
				end
				if (cmd.scan_rd) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
			end
			proc_s1 <= cmd.scan_rd;
			if (proc_s1 && proc_first) begin
				found_q <= 1'b0;
			end else if (cand) begin
				found_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		proc_idx_s1 <= rd_idx_q;
		best_smear_b_q <= smear_s(best_bytes_q);
		if (proc_s1) begin
			if (proc_first || (rd_smear != run_smear_q)) begin
				run_start_q <= proc_idx_s1;
				run_smear_q <= rd_smear;
				run_bytes_q <= rd_ext;
			end else begin
				run_bytes_q <= run_bytes_q + rd_ext;
			end
		end
		if (cand) begin
			best_smear_q <= run_smear_q;
			best_start_q <= run_start_q;
			best_end_q <= cls_end;
			best_bytes_q <= run_bytes_q;
		end else if (cmd.ext_chk && !ext_stop) begin
			best_start_q <= prev_idx;
			best_bytes_q <= best_bytes_q + rd_ext;
		end
	end

	assign last_idx = best_end_q - CNT_W'(1);
	assign first_wide = {{IDX_OUT_W{1'b0}}, best_start_q};
	assign last_wide = {{IDX_OUT_W{1'b0}}, last_idx};
	assign bytes_wide = {{BYTES_OUT_W{1'b0}}, best_bytes_q};

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			compact_needed <= found_q;
			range_first <= found_q ? first_wide[IDX_OUT_W-1:0] : '0;
			range_last <= found_q ? last_wide[IDX_OUT_W-1:0] : '0;
			range_bytes <= found_q ? bytes_wide[BYTES_OUT_W-1:0] : '0;
			if (ovf_q) begin
				status <= STATUS_OVERFLOW;
			end else if (clamp_q) begin
				status <= STATUS_CLAMP;
			end else begin
				status <= STATUS_OK;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign sts.rd_last = (rd_idx_q == (count_q - CNT_W'(1)));
	assign sts.found = found_q;
	assign sts.start_zero = (best_start_q == '0);
	assign sts.start_one = (best_start_q == CNT_W'(1));
	assign sts.ext_stop = ext_stop;
	assign sts.out_free = !out_valid_q || out_ready;
endmodule

// ----- hw/rtl/compaction_segment_picker.sv -----
// top level of the compaction segment picker
//
// Tables are loaded oldest first, one per clock while the picker is in its
// load state, and each adjusted size (raw size minus overhead_bytes, clamped
// to 1) goes into a single-port size memory. After the table marked last,
// the picker walks the n stored sizes once to find the run to compact. It
// then grows the range backwards one older table at a time, because each
// step reads the single memory port and then decides on the registered
// data. The result is then loaded into an output register; new tables are
// taken again as soon as the result is loaded there, and the pick of a
// following list waits only if the previous result has not been taken yet.
// Configuration writes are taken in every cycle.
module compaction_segment_picker #(
	parameter int MAX_TABLES = 64,
	parameter int SIZE_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	csp_table_if.sink tables,
	csp_result_if.source result,
	csp_cfg_if.sink cfg
);
	import csp_pkg::*;

	csp_cmd_t cmd;
	csp_sts_t sts;
	logic     in_ready;

	csp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tables.valid),
		.in_last  (tables.last_table),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csp_datapath #(
		.MAX_TABLES (MAX_TABLES),
		.SIZE_BITS  (SIZE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg.valid),
		.cfg_data       (cfg.overhead_bytes),
		.table_size     (tables.table_size),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.compact_needed (result.compact_needed),
		.range_first    (result.range_first),
		.range_last     (result.range_last),
		.range_bytes    (result.range_bytes),
		.status         (result.status)
	);

	assign tables.ready = in_ready;
	assign cfg.ready = 1'b1;
endmodule

// ----- sim/csp_range_checker.sv -----
`timescale 1ns / 1ps
// scoreboard that predicts the chosen compaction range and checks each result
module csp_range_checker #(
	parameter int MAX_TABLES = 64,
	parameter int SIZE_BITS = 48
) (
	input logic clk,
	csp_table_if tables,
	csp_result_if result,
	csp_cfg_if cfg,
	output int mismatches,
	output int picks_waiting
);
	import csp_pkg::*;

	localparam int PRINT_LIMIT = 100;

	typedef struct packed {
		logic                   needed;
		logic [IDX_OUT_W-1:0]   first;
		logic [IDX_OUT_W-1:0]   last;
		logic [BYTES_OUT_W-1:0] bytes;
		logic [STATUS_W-1:0]    status;
	} pick_t;

	logic [SIZE_BITS-1:0] adj_size [MAX_TABLES];
	int unsigned n_stored = 0;
	logic seen_clamp = 1'b0;
	logic seen_overflow = 1'b0;
	logic [OVH_W-1:0] overhead = OVERHEAD_RESET;
	pick_t picks_due [$];
	int fail_total = 0;
	int due_count = 0;

	assign mismatches = fail_total;
	assign picks_waiting = due_count;

	function automatic int log2_floor(logic [63:0] v);
		int l;
		l = -1;
		for (int b = 0; b < 64; b++)
			if (v[b])
				l = b;
		return l;
	endfunction

	// pick the lowest-log run of two or more, then grow it toward older tables
	function automatic pick_t choose_range();
		pick_t p;
		logic found;
		int best_log, run_log;
		int unsigned best_start, best_end, run_start, i;
		logic [63:0] best_bytes, run_bytes;
		found = 1'b0;
		best_log = 0;
		best_start = 0;
		best_end = 0;
		best_bytes = '0;
		run_start = 0;
		run_log = log2_floor(64'(adj_size[0]));
		run_bytes = 64'(adj_size[0]);
		for (i = 1; i <= n_stored; i++) begin
			if (i == n_stored || log2_floor(64'(adj_size[i])) != run_log) begin
				if (i - run_start >= 2 && (!found || run_log < best_log)) begin
					found = 1'b1;
					best_log = run_log;
					best_start = run_start;
					best_end = i;
					best_bytes = run_bytes;
				end
				if (i < n_stored) begin
					run_start = i;
					run_log = log2_floor(64'(adj_size[i]));
					run_bytes = '0;
				end
			end
			if (i < n_stored)
				run_bytes += 64'(adj_size[i]);
		end
		p = '0;
		if (found) begin
			while (best_start > 0 &&
					log2_floor(best_bytes) >= log2_floor(64'(adj_size[best_start-1]))) begin
				best_start--;
				best_bytes += 64'(adj_size[best_start]);
			end
			p.needed = 1'b1;
			p.first = IDX_OUT_W'(best_start);
			p.last = IDX_OUT_W'(best_end - 1);
			p.bytes = best_bytes[BYTES_OUT_W-1:0];
		end
		p.status = seen_overflow ? STATUS_OVERFLOW : (seen_clamp ? STATUS_CLAMP : STATUS_OK);
		return p;
	endfunction

	task automatic take_table(logic [SIZE_BITS-1:0] raw, logic is_last);
		logic [SIZE_BITS-1:0] adj;
		if (raw <= overhead) begin
			adj = 'd1;
			seen_clamp = 1'b1;
		end else begin
			adj = raw - overhead;
		end
		if (n_stored < MAX_TABLES) begin
			adj_size[n_stored] = adj;
			n_stored++;
		end else begin
			// surplus table is dropped, even the newest one
			seen_overflow = 1'b1;
		end
		if (is_last) begin
			picks_due.push_back(choose_range());
			n_stored = 0;
			seen_clamp = 1'b0;
			seen_overflow = 1'b0;
		end
	endtask

	task automatic report(string what);
		if (fail_total < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $time, what);
		fail_total++;
	endtask

	always @(posedge clk) begin : watch
		pick_t want;
		if (result.valid === 1'b1 && result.ready === 1'b1) begin
			if (picks_due.size() == 0) begin
				report("result transfer with no pick pending");
			end else begin
				want = picks_due.pop_front();
				if (result.compact_needed !== want.needed)
					report($sformatf("compact_needed %b, expected %b",
						result.compact_needed, want.needed));
				if (result.range_first !== want.first)
					report($sformatf("range_first %0d, expected %0d",
						result.range_first, want.first));
				if (result.range_last !== want.last)
					report($sformatf("range_last %0d, expected %0d",
						result.range_last, want.last));
				if (result.range_bytes !== want.bytes)
					report($sformatf("range_bytes %0d, expected %0d",
						result.range_bytes, want.bytes));
				if (result.status !== want.status)
					report($sformatf("status %0d, expected %0d", result.status, want.status));
			end
		end
		if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
			overhead = cfg.overhead_bytes;
		if (tables.valid === 1'b1 && tables.ready === 1'b1)
			take_table(tables.table_size, tables.last_table);
		due_count <= picks_due.size();
	end

endmodule

// ----- sim/tb_compaction_segment_picker.sv -----
`timescale 1ns / 1ps
// testbench top: table stimulus, result back-pressure and the final verdict
module tb_compaction_segment_picker;
	import csp_pkg::*;

	localparam int MAX_TABLES = 64;
	localparam int SIZE_BITS = 48;
	localparam int HOLD_CYCLES = 800;
	localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
	localparam logic [SIZE_BITS-1:0] OV = SIZE_BITS'(OVERHEAD_RESET);

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	rx_mode_t rx_mode;
	logic hold_start;
	int fail_count;
	int picks_waiting;
	int items_sent = 0;
	int burst_left = 0;
	bit tx_bursty = 1'b0;
	logic [OVH_W-1:0] cur_ovh = OVERHEAD_RESET;

	csp_table_if #(.SIZE_BITS(SIZE_BITS)) tbl_ch ();
	csp_result_if res_ch ();
	csp_cfg_if cfg_ch ();

	compaction_segment_picker #(
		.MAX_TABLES(MAX_TABLES),
		.SIZE_BITS(SIZE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tables(tbl_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	csp_range_checker #(
		.MAX_TABLES(MAX_TABLES),
		.SIZE_BITS(SIZE_BITS)
	) chk (
		.clk(clk),
		.tables(tbl_ch),
		.result(res_ch),
		.cfg(cfg_ch),
		.mismatches(fail_count),
		.picks_waiting(picks_waiting)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// result side: stall pattern per mode plus an optional long hold-off
	initial begin : receiver
		int hold_left;
		int cyc;
		bit take;
		hold_left = 0;
		cyc = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_start)
				hold_left = HOLD_CYCLES;
			else if (hold_left > 0)
				hold_left--;
			case (rx_mode)
				RX_ALWAYS: take = 1'b1;
				RX_RANDOM: take = ($urandom_range(0, 3) != 0);
				default: take = ((cyc % 13) < 7);
			endcase
			res_ch.ready <= take && hold_left == 0;
		end
	end

	// raw size whose adjusted value has the given log, unless the raw size is capped at SIZE_MAX
	function automatic logic [SIZE_BITS-1:0] sized_table(int lg, logic [OVH_W-1:0] ovh);
		logic [63:0] adj, raw;
		adj = ({$urandom, $urandom} & ((64'd1 << lg) - 64'd1)) | (64'd1 << lg);
		raw = adj + 64'(ovh);
		if (raw > 64'(SIZE_MAX))
			raw = 64'(SIZE_MAX);
		return raw[SIZE_BITS-1:0];
	endfunction

	task automatic put_table(logic [SIZE_BITS-1:0] raw, logic is_last);
		if (tx_bursty && burst_left == 0) begin
			tbl_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		tbl_ch.valid <= 1'b1;
		tbl_ch.table_size <= raw;
		tbl_ch.last_table <= is_last;
		@(posedge clk);
		while (!tbl_ch.ready)
			@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		items_sent++;
	endtask

	task automatic write_overhead(logic [OVH_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.overhead_bytes <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		cur_ovh = v;
	endtask

	// stop offering tables and wait until every pick has come out
	task automatic drain(int extra);
		tbl_ch.valid <= 1'b0;
		@(posedge clk);
		while (picks_waiting != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// mostly shrinking logs from oldest to newest so that ranges grow backwards
	task automatic run_list(int len);
		int lg, pick, step;
		logic [63:0] wide;
		logic [SIZE_BITS-1:0] raw;
		lg = $urandom_range(4, SIZE_BITS - 1);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 7) begin
				wide = {$urandom, $urandom};
				raw = wide[SIZE_BITS-1:0];
			end else if (pick < 12) begin
				raw = SIZE_BITS'($urandom_range(0, cur_ovh));
			end else if (pick < 14) begin
				raw = (pick == 12) ? '0 : SIZE_MAX;
			end else begin
				raw = sized_table(lg, cur_ovh);
			end
			put_table(raw, i == len - 1);
			step = $urandom_range(0, 9);
			if (step == 9)
				lg = $urandom_range(0, SIZE_BITS - 1);
			else if (step == 8)
				lg -= $urandom_range(2, 4);
			else if (step >= 6)
				lg--;
			if (lg < 0)
				lg = $urandom_range(0, SIZE_BITS - 1);
		end
	endtask

	task automatic random_lists(int upto);
		int pick, len;
		while (items_sent < upto) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				len = $urandom_range(MAX_TABLES + 1, MAX_TABLES + 6);
			else if (pick < 10)
				len = $urandom_range(13, MAX_TABLES);
			else
				len = $urandom_range(1, 12);
			run_list(len);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		tbl_ch.valid <= 1'b0;
		tbl_ch.table_size <= '0;
		tbl_ch.last_table <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.overhead_bytes <= OVERHEAD_RESET;
		rx_mode <= RX_ALWAYS;
		hold_start <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single table at zero: clamped, no run
		put_table('0, 1'b1);
		// two runs, the lower log wins
		put_table(SIZE_MAX, 1'b0);
		put_table(SIZE_MAX, 1'b0);
		put_table(OV + 'd1000, 1'b0);
		put_table(OV + 'd1000, 1'b1);
		// two runs on the same log, the older one wins
		put_table(OV + 'd8, 1'b0);
		put_table(OV + 'd9, 1'b0);
		put_table(OV + 'd100, 1'b0);
		put_table(OV + 'd8, 1'b0);
		put_table(OV + 'd15, 1'b1);
		// range grows back over every older table
		put_table(OV + 'd4000, 1'b0);
		put_table(OV + 'd1000, 1'b0);
		put_table(OV + 'd600, 1'b0);
		put_table(OV + 'd300, 1'b0);
		put_table(OV + 'd300, 1'b1);
		// size equal to and below overhead next to one just above
		put_table(OV, 1'b0);
		put_table(OV + 'd1, 1'b0);
		put_table('d50, 1'b1);
		// all logs distinct
		put_table(OV + 'd1, 1'b0);
		put_table(OV + 'd2, 1'b0);
		put_table(OV + 'd4, 1'b0);
		put_table(OV + 'd8, 1'b1);
		drain(8);

		// zero overhead, bursty sender, random stalls
		write_overhead('0);
		rx_mode <= RX_RANDOM;
		tx_bursty = 1'b1;
		// too many tables with a clamp in front: both flags at once
		put_table('0, 1'b0);
		for (int i = 1; i <= MAX_TABLES + 1; i++)
			put_table(sized_table($urandom_range(0, 12), cur_ovh), i == MAX_TABLES + 1);
		random_lists(500);
		drain(8);

		// largest overhead, no idling on either side
		write_overhead('1);
		rx_mode <= RX_ALWAYS;
		tx_bursty = 1'b0;
		random_lists(850);
		drain(8);

		write_overhead(OVH_W'($urandom_range(1, 65534)));
		rx_mode <= RX_PATTERN;
		tx_bursty = 1'b1;
		random_lists(1250);
		drain(8);

		// long result hold-off while tables keep coming
		write_overhead(OVH_W'($urandom_range(1, 65534)));
		rx_mode <= RX_RANDOM;
		tx_bursty = 1'b0;
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		random_lists(1550);
		drain(8);

		write_overhead(OVERHEAD_RESET);
		tx_bursty = 1'b1;
		random_lists(1950);
		drain(300);

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/csp_pkg.sv
hw/rtl/csp_if.sv
hw/rtl/csp_ram.sv
hw/rtl/csp_ctrl.sv
hw/rtl/csp_datapath.sv
hw/rtl/compaction_segment_picker.sv
sim/csp_range_checker.sv
sim/tb_compaction_segment_picker.sv
